// File: hdl/fpa_pkg.sv
// Shared types, codes and sizes of the fixed block pool allocator.
package fpa_pkg;

  localparam int MAX_BLOCKS    = 256;
  localparam int POINTER_BYTES = 4;
  localparam int ADDR_W        = 32;
  localparam int SIZE_W        = 16;
  localparam int IDX_W         = $clog2(MAX_BLOCKS);
  localparam int CNT_W         = $clog2(MAX_BLOCKS + 1);
  localparam int PROD_W        = IDX_W + SIZE_W;
  localparam int CFG_IDX_W     = 2;

  localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(POINTER_BYTES);

  // action codes
  localparam logic [1:0] ACT_TAKE   = 2'd0;
  localparam logic [1:0] ACT_GIVE   = 2'd1;
  localparam logic [1:0] ACT_CREATE = 2'd2;

  // status codes
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_BAD_ADDR  = 3'd1;
  localparam logic [2:0] ST_MISALIGN  = 3'd2;
  localparam logic [2:0] ST_BAD_COUNT = 3'd3;
  localparam logic [2:0] ST_BAD_SIZE  = 3'd4;
  localparam logic [2:0] ST_NONE_FREE = 3'd5;
  localparam logic [2:0] ST_FULL      = 3'd6;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_BASE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SIZE  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_COUNT = 2'd2;

  typedef struct packed {
    logic [1:0]       action;
    logic [IDX_W-1:0] block_index;
  } in_item_t;

  typedef struct packed {
    logic [2:0]        status;
    logic [IDX_W-1:0]  granted_index;
    logic [ADDR_W-1:0] granted_address;
    logic [CNT_W-1:0]  free_blocks;
  } out_item_t;

  typedef struct packed {
    logic [ADDR_W-1:0] base_address;
    logic [SIZE_W-1:0] block_size;
    logic [CNT_W-1:0]  block_count;
  } cfg_regs_t;

  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] waddr;
    logic [IDX_W-1:0] wdata;
    logic [IDX_W-1:0] raddr;
  } link_req_t;

  function automatic out_item_t make_result(input logic [2:0]        status,
                                            input logic [IDX_W-1:0]  gidx,
                                            input logic [ADDR_W-1:0] gaddr,
                                            input logic [CNT_W-1:0]  free_n);
    out_item_t r;
    r.status          = status;
    r.granted_index   = gidx;
    r.granted_address = gaddr;
    r.free_blocks     = free_n;
    return r;
  endfunction

endpackage

// File: hdl/fpa_link_ram.sv
// Next-link memory of the free list: one write port, one registered read port.
module fpa_link_ram (
  input  logic                     clk,
  input  fpa_pkg::link_req_t       req,
  output logic [fpa_pkg::IDX_W-1:0] rdata
);

  logic [fpa_pkg::IDX_W-1:0] mem [fpa_pkg::MAX_BLOCKS];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    rdata <= mem[req.raddr];
  end

endmodule

// File: hdl/fpa_ctrl.sv
// Allocator sequencer: create checks, link sweep, take and give on the link memory.
module fpa_ctrl (
  input  logic                      clk,
  input  logic                      rst,
  input  fpa_pkg::cfg_regs_t        cfg,
  input  logic                      start,
  input  fpa_pkg::in_item_t         item,
  output logic                      busy,
  output logic                      result_valid,
  output fpa_pkg::out_item_t        result,
  output fpa_pkg::link_req_t        link_req,
  input  logic [fpa_pkg::IDX_W-1:0] link_rdata
);

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_TAKE  = 3'b010,
    S_SWEEP = 3'b100
  } state_t;

  localparam logic [fpa_pkg::ADDR_W-1:0] PTR_MASK_A = fpa_pkg::ADDR_W'(fpa_pkg::POINTER_BYTES - 1);
  localparam logic [fpa_pkg::SIZE_W-1:0] PTR_MASK_S = fpa_pkg::SIZE_W'(fpa_pkg::POINTER_BYTES - 1);

  state_t                      state;
  logic [fpa_pkg::IDX_W-1:0]   head;
  logic [fpa_pkg::CNT_W-1:0]   free_count;
  logic [fpa_pkg::CNT_W-1:0]   pool_blocks;
  logic [fpa_pkg::ADDR_W-1:0]  pool_base;
  logic [fpa_pkg::SIZE_W-1:0]  pool_size;
  logic [fpa_pkg::IDX_W-1:0]   sweep_idx;
  logic [fpa_pkg::IDX_W-1:0]   sweep_last;

  logic                        accept;
  logic [2:0]                  create_status;
  logic                        give_in_range;
  logic                        give_ok;
  logic                        take_ok;
  logic [fpa_pkg::PROD_W-1:0]  prod;
  logic [fpa_pkg::ADDR_W-1:0]  grant_addr;
  logic [fpa_pkg::CNT_W-1:0]   count_minus_one;

  assign busy   = (state != S_IDLE);
  assign accept = start && !busy;

  // create checks, later ones take priority
  always_comb begin
    create_status = fpa_pkg::ST_OK;
    if (cfg.base_address == '0) begin
      create_status = fpa_pkg::ST_BAD_ADDR;
    end
    if ((cfg.base_address & PTR_MASK_A) != '0) begin
      create_status = fpa_pkg::ST_MISALIGN;
    end
    if (cfg.block_count < fpa_pkg::CNT_W'(2) ||
        cfg.block_count > fpa_pkg::CNT_W'(fpa_pkg::MAX_BLOCKS)) begin
      create_status = fpa_pkg::ST_BAD_COUNT;
    end
    if (cfg.block_size < fpa_pkg::SIZE_W'(fpa_pkg::POINTER_BYTES) ||
        (cfg.block_size & PTR_MASK_S) != '0) begin
      create_status = fpa_pkg::ST_BAD_SIZE;
    end
  end

  assign give_in_range   = fpa_pkg::CNT_W'(item.block_index) < pool_blocks;
  assign give_ok         = give_in_range && (free_count < pool_blocks);
  assign take_ok         = (free_count != '0);
  assign prod            = fpa_pkg::PROD_W'(head) * fpa_pkg::PROD_W'(pool_size);
  assign grant_addr      = pool_base + fpa_pkg::ADDR_W'(prod);
  assign count_minus_one = cfg.block_count - fpa_pkg::CNT_W'(1);

  // link memory port: sweep owns the write port while it runs
  always_comb begin
    link_req.raddr = head;
    if (state == S_SWEEP) begin
      link_req.we    = 1'b1;
      link_req.waddr = sweep_idx;
      link_req.wdata = (sweep_idx == sweep_last) ? '0 : sweep_idx + fpa_pkg::IDX_W'(1);
    end else begin
      link_req.we    = accept && (item.action == fpa_pkg::ACT_GIVE) && give_ok;
      link_req.waddr = item.block_index;
      link_req.wdata = head;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      result_valid <= 1'b0;
      head         <= '0;
      free_count   <= '0;
      pool_blocks  <= '0;
      pool_base    <= '0;
      pool_size    <= '0;
    end else begin
      result_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (accept) begin
            case (item.action)
              fpa_pkg::ACT_TAKE: begin
                if (take_ok) begin
                  state <= S_TAKE;
                end else begin
                  result_valid <= 1'b1;
                  result <= fpa_pkg::make_result(fpa_pkg::ST_NONE_FREE, '0, '0, free_count);
                end
              end
              fpa_pkg::ACT_GIVE: begin
                result_valid <= 1'b1;
                if (!give_in_range) begin
                  result <= fpa_pkg::make_result(fpa_pkg::ST_BAD_ADDR, '0, '0, free_count);
                end else if (!give_ok) begin
                  result <= fpa_pkg::make_result(fpa_pkg::ST_FULL, '0, '0, free_count);
                end else begin
                  head       <= item.block_index;
                  free_count <= free_count + fpa_pkg::CNT_W'(1);
                  result     <= fpa_pkg::make_result(fpa_pkg::ST_OK, '0, '0,
                                                     free_count + fpa_pkg::CNT_W'(1));
                end
              end
              fpa_pkg::ACT_CREATE: begin
                if (create_status != fpa_pkg::ST_OK) begin
                  result_valid <= 1'b1;
                  result <= fpa_pkg::make_result(create_status, '0, '0, free_count);
                end else begin
                  head        <= '0;
                  free_count  <= cfg.block_count;
                  pool_blocks <= cfg.block_count;
                  pool_base   <= cfg.base_address;
                  pool_size   <= cfg.block_size;
                  sweep_idx   <= '0;
                  sweep_last  <= count_minus_one[fpa_pkg::IDX_W-1:0];
                  state       <= S_SWEEP;
                end
              end
              default: begin
                result_valid <= 1'b1;
                result <= fpa_pkg::make_result(fpa_pkg::ST_OK, '0, '0, free_count);
              end
            endcase
          end
        end
        S_TAKE: begin
          // link data for the old head is valid now
          head         <= link_rdata;
          free_count   <= free_count - fpa_pkg::CNT_W'(1);
          result_valid <= 1'b1;
          result       <= fpa_pkg::make_result(fpa_pkg::ST_OK, head, grant_addr,
                                               free_count - fpa_pkg::CNT_W'(1));
          state        <= S_IDLE;
        end
        S_SWEEP: begin
          if (sweep_idx == sweep_last) begin
            result_valid <= 1'b1;
            result <= fpa_pkg::make_result(fpa_pkg::ST_OK, '0, '0, free_count);
            state  <= S_IDLE;
          end else begin
            sweep_idx <= sweep_idx + fpa_pkg::IDX_W'(1);
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    free_count <= pool_blocks)
    else $error("free count exceeds pool size");

  a_head_in_pool: assert property (@(posedge clk) disable iff (rst)
    (free_count != '0) |-> (fpa_pkg::CNT_W'(head) < pool_blocks))
    else $error("free list head outside pool");

  a_take_one_cycle: assert property (@(posedge clk) disable iff (rst)
    (state == S_TAKE) |=> (state == S_IDLE) && result_valid)
    else $error("take did not finish in one cycle");

  a_sweep_in_pool: assert property (@(posedge clk) disable iff (rst)
    (state == S_SWEEP) |-> (fpa_pkg::CNT_W'(sweep_idx) < pool_blocks))
    else $error("link sweep beyond pool");

endmodule

// File: hdl/fixed_block_pool_allocator.sv
// Top level of the fixed block pool allocator: configuration registers and core.
//
// Usage:
//  - Configuration: write base_address (index 0), block_size (index 1) and
//    block_count (index 2) through cfg_valid/cfg_index/cfg_data; cfg_ready is
//    always high, so a write lands at every edge with cfg_valid high. Unknown
//    indexes are ignored. Write only while the block is idle.
//  - Commands: drive item and raise start; the item is taken at an edge where
//    start is high and busy is low. Action 0 takes a block, 1 gives one back,
//    2 creates the pool from the registers.
//  - Results: one per item, on result for a single cycle with result_valid
//    high. The receiver cannot hold a result off, and none is buffered.
//  - Latency and rate: give, failed take and failed create answer in the
//    cycle after acceptance, one item per cycle. A successful take waits in
//    S_TAKE for the link memory read of the head, so it answers when it
//    leaves S_TAKE and accepts the next item then. A successful create sweeps
//    the link memory, one entry per cycle on its single write port, and
//    stays busy until the last entry is written.
//  - Reset (rst, synchronous): empties the pool and clears the registers
//    (block_size returns to 4); the link memory is not cleared.
module fixed_block_pool_allocator (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [fpa_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [fpa_pkg::ADDR_W-1:0]    cfg_data,
  input  logic                          start,
  input  fpa_pkg::in_item_t             item,
  output logic                          busy,
  output logic                          result_valid,
  output fpa_pkg::out_item_t            result
);

  fpa_pkg::cfg_regs_t        cfg;
  fpa_pkg::link_req_t        link_req;
  logic [fpa_pkg::IDX_W-1:0] link_rdata;

  // configuration never stalls
  assign cfg_ready = 1'b1;

  // hold the register values; each write truncates to the register's width
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.base_address <= '0;
      cfg.block_size   <= fpa_pkg::SIZE_RESET;
      cfg.block_count  <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        fpa_pkg::CFG_BASE:  cfg.base_address <= cfg_data;
        fpa_pkg::CFG_SIZE:  cfg.block_size   <= cfg_data[fpa_pkg::SIZE_W-1:0];
        fpa_pkg::CFG_COUNT: cfg.block_count  <= cfg_data[fpa_pkg::CNT_W-1:0];
        default: begin
          // drop writes to unknown indexes
        end
      endcase
    end
  end

  // sequencer: checks, sweep, pop and push
  fpa_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .start        (start),
    .item         (item),
    .busy         (busy),
    .result_valid (result_valid),
    .result       (result),
    .link_req     (link_req),
    .link_rdata   (link_rdata)
  );

  // next-link storage, read data registered in the cycle after the address
  fpa_link_ram u_link_ram (
    .clk   (clk),
    .req   (link_req),
    .rdata (link_rdata)
  );

endmodule
